// ----- design/ile_pkg.sv -----
// Shared types and constants for the indexed list engine.
`default_nettype none

package ile_pkg;

    // Request selector codes
    typedef enum logic [2:0] {
        FUNC_READ   = 3'd0,
        FUNC_HEAD   = 3'd1,
        FUNC_TAIL   = 3'd2,
        FUNC_AT     = 3'd3,
        FUNC_DELETE = 3'd4
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Action broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_READ   = 2'd3
    } cell_op_t;

    // Slot index wide enough for the largest supported capacity (0..1024)
    localparam int SLOT_W = 11;
    localparam int DATA_W = 32;

    typedef struct packed {
        cell_op_t            op;
        logic [SLOT_W-1:0]   slot;
        logic [DATA_W-1:0]   value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/ile_cell.sv -----
// One list slot: holds an entry and shifts it to or from its neighbors.
`default_nettype none

module ile_cell
    import ile_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic              clk,
    input  wire cell_ctl_t         ctl,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] rd_data
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [DATA_W-1:0] rd_reg;
    logic [DATA_W-1:0] rd_next;

    // Entry update: open a gap on insert, close it on delete
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_INSERT:
            begin
                if (MY_SLOT > ctl.slot)
                    data_next = left_data;
                else if (MY_SLOT == ctl.slot)
                    data_next = ctl.value;
            end
            CELL_DELETE:
            begin
                if (MY_SLOT >= ctl.slot)
                    data_next = right_data;
            end
            CELL_HOLD, CELL_READ:
                data_next = data_reg;
        endcase
    end

    // Read contribution: only the addressed cell puts its entry on the bus
    assign rd_next = (ctl.op == CELL_READ && MY_SLOT == ctl.slot) ? data_reg : '0;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_reg   <= rd_next;
    end

    assign data    = data_reg;
    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ----- design/indexed_list_engine.sv -----
// Top level of the indexed list engine: request decode, count and cell row.
//
// Ordered list of signed 32-bit entries addressed by position, held in a row
// of CAPACITY cells. A request is taken on any cycle with start high and busy
// low; busy stays low, so one request enters every clock. Insert and delete
// shift all later entries by one place in the same cycle through the cell
// row. The result comes on the cycle after the request, marked by done for
// exactly one cycle, and must be taken then: the receiver cannot stall it.
// The read path is one registered per-cell select followed by an OR across
// all cells. There is no clearing pass after reset.
`default_nettype none

module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         func,
    input  wire logic signed [10:0] position,
    input  wire logic signed [31:0] item_value,
    output logic                    done,
    output logic                    found,
    output logic signed [31:0]      read_value,
    output logic [1:0]              status,
    output logic [6:0]              list_length
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    logic          found_reg;
    status_t       status_reg;
    status_t       status_next;
    logic          found_next;

    cell_ctl_t     ctl;
    logic          accept;
    logic          is_full;
    logic          pos_neg;
    logic [SLOT_W-1:0] pos_u;
    logic [SLOT_W-1:0] cnt_s;
    logic          idx_ok;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];
    logic [DATA_W-1:0] rd_or;
    logic [CW+6:0]     len_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Position and occupancy checks
    assign pos_neg = position[10];
    assign pos_u   = {1'b0, position[9:0]};
    assign cnt_s   = SLOT_W'(count_reg);
    assign is_full = (count_reg == CAP_C);
    assign idx_ok  = !pos_neg && (pos_u < cnt_s);

    // Request decode
    always_comb
    begin
        ctl.op      = CELL_HOLD;
        ctl.slot    = pos_u;
        ctl.value   = item_value;
        status_next = ST_DONE;
        found_next  = 1'b0;
        count_next  = count_reg;
        unique case (func)
            FUNC_READ:
            begin
                if (idx_ok)
                begin
                    ctl.op     = CELL_READ;
                    found_next = 1'b1;
                end
                else
                    status_next = ST_RANGE;
            end
            FUNC_HEAD:
            begin
                ctl.slot = '0;
                if (is_full)
                    status_next = ST_FULL;
                else
                    ctl.op = CELL_INSERT;
            end
            FUNC_TAIL:
            begin
                ctl.slot = cnt_s;
                if (is_full)
                    status_next = ST_FULL;
                else
                    ctl.op = CELL_INSERT;
            end
            FUNC_AT:
            begin
                if (pos_neg)
                    ctl.slot = '0;
                if (!pos_neg && pos_u > cnt_s)
                    status_next = ST_RANGE;
                else if (is_full)
                    status_next = ST_FULL;
                else
                    ctl.op = CELL_INSERT;
            end
            FUNC_DELETE:
            begin
                if (idx_ok)
                    ctl.op = CELL_DELETE;
                else
                    status_next = ST_RANGE;
            end
            default:
                status_next = ST_RANGE;
        endcase
        if (ctl.op == CELL_INSERT)
            count_next = count_reg + 1'b1;
        else if (ctl.op == CELL_DELETE)
            count_next = count_reg - 1'b1;
        if (!accept)
        begin
            ctl.op     = CELL_HOLD;
            count_next = count_reg;
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (accept)
            begin
                found_reg  <= found_next;
                status_reg <= status_next;
            end
        end
    end

    // Cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = item_value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            ile_cell #(
                .IDX (gi)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .rd_data    (cell_rd[gi])
            );
        end
    endgenerate

    // Read bus: at most one cell drives a nonzero word
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_or = rd_or | cell_rd[i];
    end

    assign len_ext     = {7'b0, count_reg};
    assign done        = done_reg;
    assign found       = found_reg;
    assign read_value  = found_reg ? rd_or : '1;
    assign status      = status_reg;
    assign list_length = len_ext[6:0];

endmodule

`default_nettype wire
